@@ rtl/fp_cvt_pkg.sv @@
package fp_cvt_pkg;

   // Operation codes carried on req_op.
   localparam logic OP_S2H = 1'b0;
   localparam logic OP_H2S = 1'b1;

   // Single precision exponent bounds, as biased field values.
   localparam logic [7:0] SGL_EXP_MAX   = 8'hff;
   localparam logic [7:0] SGL_EXP_TINY  = 8'd102;
   localparam logic [7:0] SGL_EXP_HNORM = 8'd113;
   localparam logic [7:0] SGL_EXP_HOVF  = 8'd142;
   localparam logic [7:0] SGL_SUB_BASE  = 8'd126;

   // Half exponent bias adjustments into single precision.
   localparam logic [7:0] H2S_BIAS_NORM = 8'd112;
   localparam logic [7:0] H2S_BIAS_SUB  = 8'd113;

   // Canonical special results.
   localparam logic [31:0] HALF_NAN   = 32'h0000_7fff;
   localparam logic [14:0] HALF_INF   = 15'h7c00;
   localparam logic [30:0] SGL_INF    = 31'h7f80_0000;
   localparam logic [31:0] SGL_NAN    = 32'h7fff_ffff;
   localparam logic [4:0]  HALF_EXP_MAX = 5'h1f;

   // Normal half results keep 13 discarded fraction bits.
   localparam logic [4:0] NORM_SHIFT = 5'd13;
   localparam logic [4:0] STICKY_TOP = 5'd25;

   // Stage 1: decoded operand.
   typedef struct packed {
      logic        op;
      logic        special;
      logic [31:0] special_val;
      logic        sign;
      logic [23:0] sig;       // single significand, or half fraction in the low bits
      logic [4:0]  shift;     // right shift for S2H, left normalize for H2S
      logic [7:0]  expo;      // S2H: exponent to add at bit 10; H2S: final exponent
   } s1_type;

   // Stage 2: assembled result before the rounding increment.
   typedef struct packed {
      logic        op;
      logic [31:0] base;
      logic        inc;
   } s2_type;

   // Number of leading zeros in a nonzero half subnormal fraction, plus one:
   // the left shift that brings the top set bit to the implicit position.
   function automatic logic [4:0] norm_count(input logic [9:0] m);
      logic [4:0] n;
      n = 5'd10;
      for (int i = 0; i < 10; i++) begin
         if (m[i]) begin
            n = 5'(10 - i);
         end
      end
      return n;
   endfunction

endpackage

@@ rtl/fp32_fp16_converter.sv @@
// IEEE-754 single/half precision converter. Each beat on the req_ channel
// carries an op bit (0 converts binary32 to binary16, 1 converts binary16 in
// the low 16 bits of req_operand to binary32) and produces exactly one beat
// on the rsp_ channel, in order. Single to half rounds to nearest, ties to
// even, produces half subnormals, and lets a rounding carry reach infinity;
// any NaN becomes 0x7fff. Half to single is exact; any NaN becomes
// 0x7fffffff and both half zeros become +0. The datapath is a three stage
// pipeline (decode, shift, round) that sustains one beat per clock when the
// consumer keeps rsp_ready high. Every stage carries its own valid bit and
// holds its contents while the stage after it is full and stalled, so no
// beat is lost or repeated under back pressure. There is no configuration
// and no state beyond the pipeline registers.
module fp32_fp16_converter
   import fp_cvt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [31:0] req_operand,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_converted
);

   // Pipeline valid bits and payload registers.
   logic        v1_ff, v2_ff, v3_ff;
   s1_type      s1_ff, s1_in;
   s2_type      s2_ff, s2_in;
   logic        s3_op_ff;
   logic [31:0] s3_res_ff, s3_res_in;

   // A stage may load when it is empty or when its content moves on.
   logic rdy1, rdy2, rdy3;

   assign rdy3      = !v3_ff || rsp_ready;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_ready = rdy1;

   // Stage 1: classify the operand and work out the shift amounts.
   always_comb begin
      logic        sgn;
      logic [7:0]  expf;
      logic [22:0] frac;
      logic [4:0]  he;
      logic [9:0]  hm;
      logic [4:0]  n;

      sgn  = req_operand[31];
      expf = req_operand[30:23];
      frac = req_operand[22:0];
      he   = req_operand[14:10];
      hm   = req_operand[9:0];
      n    = norm_count(hm);

      s1_in             = '0;
      s1_in.op          = req_op;

      unique case (req_op)
         OP_S2H: begin
            s1_in.sign = sgn;
            s1_in.sig  = {1'b1, frac};
            if (expf == SGL_EXP_MAX) begin
               // Infinity keeps its sign; every NaN collapses to one pattern.
               s1_in.special     = 1'b1;
               s1_in.special_val = (frac == '0) ? {16'b0, sgn, HALF_INF} : HALF_NAN;
            end else if (expf < SGL_EXP_TINY) begin
               s1_in.special     = 1'b1;
               s1_in.special_val = {16'b0, sgn, 15'b0};
            end else if (expf > SGL_EXP_HOVF) begin
               s1_in.special     = 1'b1;
               s1_in.special_val = {16'b0, sgn, HALF_INF};
            end else if (expf < SGL_EXP_HNORM) begin
               // Half subnormal: shift of 14 to 24, no exponent field.
               s1_in.shift = 5'(SGL_SUB_BASE - expf);
               s1_in.expo  = '0;
            end else begin
               s1_in.shift = NORM_SHIFT;
               s1_in.expo  = expf - SGL_EXP_HNORM;
            end
         end
         OP_H2S: begin
            s1_in.sign = req_operand[15];
            s1_in.sig  = {14'b0, hm};
            if (he == HALF_EXP_MAX) begin
               s1_in.special     = 1'b1;
               s1_in.special_val = (hm == '0) ? {req_operand[15], SGL_INF} : SGL_NAN;
            end else if (he != '0) begin
               s1_in.shift = '0;
               s1_in.expo  = {3'b0, he} + H2S_BIAS_NORM;
            end else if (hm == '0) begin
               s1_in.special     = 1'b1;
               s1_in.special_val = '0;
            end else begin
               // Half subnormal: normalize into a single precision normal.
               s1_in.shift = n;
               s1_in.expo  = H2S_BIAS_SUB - {3'b0, n};
            end
         end
         default: begin
            s1_in = '0;
         end
      endcase
   end

   // Stage 2: barrel shift, form the round and sticky bits, place the exponent.
   always_comb begin
      logic [23:0] q;
      logic [23:0] rb;
      logic [23:0] st;
      logic [10:0] mn;
      logic        sticky;

      q      = s1_ff.sig >> s1_ff.shift;
      rb     = s1_ff.sig >> (s1_ff.shift - 5'd1);
      st     = s1_ff.sig << (STICKY_TOP - s1_ff.shift);
      sticky = |st;
      mn     = 11'(s1_ff.sig[10:0] << s1_ff.shift);

      s2_in.op   = s1_ff.op;
      s2_in.base = '0;
      s2_in.inc  = 1'b0;
      if (s1_ff.special) begin
         s2_in.base = s1_ff.special_val;
      end else if (s1_ff.op == OP_S2H) begin
         s2_in.base = {16'b0, s1_ff.sign,
                       {4'b0, q[10:0]} + {s1_ff.expo[4:0], 10'b0}};
         // Round to nearest, ties to even.
         s2_in.inc  = rb[0] && (sticky || q[0]);
      end else begin
         s2_in.base = {s1_ff.sign, s1_ff.expo, mn[9:0], 13'b0};
      end
   end

   // Stage 3: apply the rounding increment. The carry may run from the
   // fraction into the exponent, up to half infinity, never into the sign.
   always_comb begin
      s3_res_in = s2_ff.base;
      if (s2_ff.inc) begin
         s3_res_in[14:0] = s2_ff.base[14:0] + 15'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) s1_ff <= s1_in;
      if (rdy2) s2_ff <= s2_in;
      if (rdy3) begin
         s3_res_ff <= s3_res_in;
         s3_op_ff  <= s2_ff.op;
      end
   end

   assign rsp_valid     = v3_ff;
   assign rsp_converted = s3_res_ff;

`ifndef SYNTHESIS
   // Back pressure reaches the input only with every stage full and stalled.
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (v1_ff && v2_ff && v3_ff && !rsp_ready))
      else $error("req_ready low while the pipeline has room");

   // A taken request beat always lands in the first stage.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v1_ff)
      else $error("accepted beat not captured in stage 1");

   // Half results keep the upper half of the word clear.
   a_half_upper: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && s3_op_ff == OP_S2H) |-> (rsp_converted[31:16] == 16'b0))
      else $error("half result with nonzero upper bits");

   // A half NaN can only be the canonical pattern.
   a_half_nan: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && s3_op_ff == OP_S2H && rsp_converted[14:10] == HALF_EXP_MAX
       && rsp_converted[9:0] != 10'b0) |-> (rsp_converted == HALF_NAN))
      else $error("non-canonical half NaN");

   // A single NaN can only be the canonical pattern.
   a_sgl_nan: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && s3_op_ff == OP_H2S && rsp_converted[30:23] == 8'hff
       && rsp_converted[22:0] != 23'b0) |-> (rsp_converted == SGL_NAN))
      else $error("non-canonical single NaN");
`endif

endmodule
